@@ sv/stq_pkg.sv @@
// Shared types and constants for the sorted timer queue.
// Used by stq_store and sorted_timer_queue; depends on nothing else.
package stq_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int MAX_OUT    = 32;
	localparam logic [31:0] NO_DUE = 32'hffffffff;

	// Actions carried by an input beat.
	localparam logic [2:0] ACT_ALLOC = 3'd0;
	localparam logic [2:0] ACT_FREE  = 3'd1;
	localparam logic [2:0] ACT_SET   = 3'd2;
	localparam logic [2:0] ACT_ARM   = 3'd3;
	localparam logic [2:0] ACT_TICK  = 3'd4;

	// Result kinds.
	localparam logic [2:0] KIND_ACK    = 3'd0;
	localparam logic [2:0] KIND_GRANT  = 3'd1;
	localparam logic [2:0] KIND_REFUSE = 3'd2;
	localparam logic [2:0] KIND_EXPIRY = 3'd3;
	localparam logic [2:0] KIND_IDLE   = 3'd4;

	// Slot status codes.
	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_HEAD,
		S_WALK_L,
		S_WALK_D,
		S_WALK_C,
		S_LINK1,
		S_LINK2,
		S_EMIT,
		S_TK_RD,
		S_TK_CHK,
		S_TK_ERD,
		S_TK_END
	} state_t;

	// Write requests into the slot store.
	typedef struct packed {
		logic             dl_we;
		logic [IDX_W-1:0] dl_addr;
		logic [31:0]      dl_data;
		logic             link_we;
		logic [IDX_W-1:0] link_addr;
		logic [IDX_W-1:0] link_data;
		logic             tq_we;
		logic [IDX_W-1:0] tq_addr;
		logic [7:0]       tag;
		logic [2:0]       queue;
	} stq_wr_t;

	// Registered read data of one slot.
	typedef struct packed {
		logic [31:0]      deadline;
		logic [IDX_W-1:0] link;
		logic [7:0]       tag;
		logic [2:0]       queue;
	} stq_rd_t;

endpackage

@@ sv/stq_store.sv @@
// Per-slot storage: deadline, list link, tag and target queue memories.
// Depends on stq_pkg for the request and read data structs.
module stq_store (
	input  logic                     clk,
	input  stq_pkg::stq_wr_t         wr,
	input  logic [stq_pkg::IDX_W-1:0] rd_addr,
	output stq_pkg::stq_rd_t         rd
);

	logic [31:0]               dl_mem   [stq_pkg::NUM_TIMERS];
	logic [stq_pkg::IDX_W-1:0] link_mem [stq_pkg::NUM_TIMERS];
	logic [7:0]                tag_mem  [stq_pkg::NUM_TIMERS];
	logic [2:0]                q_mem    [stq_pkg::NUM_TIMERS];

	// Writes on independent enables, one shared read address with registered read data.
	always_ff @(posedge clk) begin
		if (wr.dl_we) begin
			dl_mem[wr.dl_addr] <= wr.dl_data;
		end
		if (wr.link_we) begin
			link_mem[wr.link_addr] <= wr.link_data;
		end
		if (wr.tq_we) begin
			tag_mem[wr.tq_addr] <= wr.tag;
			q_mem[wr.tq_addr]   <= wr.queue;
		end
		rd.deadline <= dl_mem[rd_addr];
		rd.link     <= link_mem[rd_addr];
		rd.tag      <= tag_mem[rd_addr];
		rd.queue    <= q_mem[rd_addr];
	end

endmodule

@@ sv/sorted_timer_queue.sv @@
// Top level of the sorted timer queue: command sequencer and list walker.
// Depends on stq_pkg and stq_store.

// A pool of one-shot timers held in a linked list sorted by deadline. One
// input beat is taken at a time; the block stalls its input until every
// result of that beat has been loaded into the output register. Arm walks
// the list unless the timer goes to the head of it; each list step reads
// the link and then the deadline through the single read port of the slot
// store, and a tick reads each expired timer through the same read port.
// Output stalls hold every action back. The slot store needs no clearing
// after reset.
module sorted_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [4:0]  timer_index,
	input  logic [31:0] delay,
	input  logic [7:0]  tag,
	input  logic [2:0]  queue_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [4:0]  slot,
	output logic [7:0]  expired_tag,
	output logic [2:0]  target_queue,
	output logic        last
);

	localparam int IW = stq_pkg::IDX_W;
	localparam int CW = stq_pkg::CNT_W;

	stq_pkg::state_t state_q, state_d;

	logic [2:0]  act_q;
	logic [4:0]  tidx_q;
	logic [31:0] delay_q;
	logic [7:0]  tag_q;
	logic [2:0]  qid_q;

	logic [31:0]   tick_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] run_q;
	logic [31:0]   early_q;
	logic [1:0]    status_q [stq_pkg::NUM_TIMERS];

	logic [31:0]   d_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] cur_q;
	logic [CW-1:0] n_q;

	logic          pend_v_q;
	logic [IW-1:0] pend_slot_q;
	logic [7:0]    pend_tag_q;
	logic [2:0]    pend_queue_q;

	logic [2:0] res_kind_q;
	logic [4:0] res_slot_q;

	logic       out_valid_q;
	logic [2:0] out_kind_q;
	logic [4:0] out_slot_q;
	logic [7:0] out_tag_q;
	logic [2:0] out_queue_q;
	logic       out_last_q;

	stq_pkg::stq_wr_t wr;
	stq_pkg::stq_rd_t rd;
	logic [IW-1:0]    rd_addr;

	logic          out_free;
	logic          out_load;
	logic [2:0]    ol_kind;
	logic [4:0]    ol_slot;
	logic [7:0]    ol_tag;
	logic [2:0]    ol_queue;
	logic          ol_last;
	logic          expire;

	logic [IW-1:0] idx;
	logic          idx_ok;
	logic [1:0]    idx_status;
	logic          cmd_bad;
	logic [31:0]   arm_sum;
	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [CW-1:0] remain;

	stq_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	// Command decode helpers.
	assign idx        = IW'(tidx_q);
	assign idx_ok     = (32'(tidx_q) < stq_pkg::NUM_TIMERS);
	assign idx_status = status_q[idx];
	assign cmd_bad    = !idx_ok || (idx_status == stq_pkg::ST_RUN) ||
		((act_q == stq_pkg::ACT_ARM) && (idx_status == stq_pkg::ST_FREE));
	assign arm_sum    = tick_q + delay_q;
	assign remain     = run_q - n_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != stq_pkg::S_IDLE);

	// Lowest free slot for allocation.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = stq_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
			if (status_q[i] == stq_pkg::ST_FREE) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// Next state, store requests and output loads.
	always_comb begin
		state_d  = state_q;
		wr       = '0;
		rd_addr  = cur_q;
		out_load = 1'b0;
		ol_kind  = res_kind_q;
		ol_slot  = res_slot_q;
		ol_tag   = '0;
		ol_queue = '0;
		ol_last  = 1'b1;
		expire   = 1'b0;
		unique case (state_q)
			stq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = stq_pkg::S_DECODE;
				end
			end
			stq_pkg::S_DECODE: begin
				state_d = stq_pkg::S_EMIT;
				if (act_q == stq_pkg::ACT_TICK) begin
					state_d = stq_pkg::S_TK_RD;
				end else if ((act_q == stq_pkg::ACT_SET) && !cmd_bad) begin
					wr.tq_we   = 1'b1;
					wr.tq_addr = idx;
					wr.tag     = tag_q;
					wr.queue   = qid_q;
				end else if ((act_q == stq_pkg::ACT_ARM) && !cmd_bad) begin
					wr.dl_we   = 1'b1;
					wr.dl_addr = idx;
					wr.dl_data = arm_sum;
					if ((run_q == '0) || (arm_sum <= early_q)) begin
						state_d = stq_pkg::S_HEAD;
					end else begin
						state_d = stq_pkg::S_WALK_L;
					end
				end
			end
			stq_pkg::S_HEAD: begin
				wr.link_we   = 1'b1;
				wr.link_addr = idx;
				wr.link_data = head_q;
				state_d      = stq_pkg::S_EMIT;
			end
			stq_pkg::S_WALK_L: begin
				rd_addr = prev_q;
				state_d = stq_pkg::S_WALK_D;
			end
			stq_pkg::S_WALK_D: begin
				rd_addr = rd.link;
				if (n_q < run_q) begin
					state_d = stq_pkg::S_WALK_C;
				end else begin
					state_d = stq_pkg::S_LINK1;
				end
			end
			stq_pkg::S_WALK_C: begin
				if (d_q <= rd.deadline) begin
					state_d = stq_pkg::S_LINK1;
				end else begin
					state_d = stq_pkg::S_WALK_L;
				end
			end
			stq_pkg::S_LINK1: begin
				wr.link_we   = 1'b1;
				wr.link_addr = idx;
				wr.link_data = cur_q;
				state_d      = stq_pkg::S_LINK2;
			end
			stq_pkg::S_LINK2: begin
				wr.link_we   = 1'b1;
				wr.link_addr = prev_q;
				wr.link_data = idx;
				state_d      = stq_pkg::S_EMIT;
			end
			stq_pkg::S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = stq_pkg::S_IDLE;
				end
			end
			stq_pkg::S_TK_RD: begin
				if ((n_q < run_q) && (32'(n_q) < stq_pkg::MAX_OUT)) begin
					state_d = stq_pkg::S_TK_CHK;
				end else begin
					state_d = stq_pkg::S_TK_ERD;
				end
			end
			stq_pkg::S_TK_CHK: begin
				if (rd.deadline > tick_q) begin
					state_d = stq_pkg::S_TK_ERD;
				end else if (!pend_v_q || out_free) begin
					// The previous expiry goes out now that another follows it.
					expire   = 1'b1;
					out_load = pend_v_q;
					ol_kind  = stq_pkg::KIND_EXPIRY;
					ol_slot  = 5'(pend_slot_q);
					ol_tag   = pend_tag_q;
					ol_queue = pend_queue_q;
					ol_last  = 1'b0;
					state_d  = stq_pkg::S_TK_RD;
				end
			end
			stq_pkg::S_TK_ERD: begin
				state_d = stq_pkg::S_TK_END;
			end
			stq_pkg::S_TK_END: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_v_q) begin
						ol_kind  = stq_pkg::KIND_EXPIRY;
						ol_slot  = 5'(pend_slot_q);
						ol_tag   = pend_tag_q;
						ol_queue = pend_queue_q;
					end else begin
						ol_kind = stq_pkg::KIND_IDLE;
						ol_slot = '0;
					end
					state_d = stq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stq_pkg::S_IDLE;
			end
		endcase
	end

	// Control state of the sequencer and the timer list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stq_pkg::S_IDLE;
			tick_q      <= '0;
			head_q      <= '0;
			run_q       <= '0;
			early_q     <= stq_pkg::NO_DUE;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < stq_pkg::NUM_TIMERS; i++) begin
				status_q[i] <= stq_pkg::ST_FREE;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				stq_pkg::S_DECODE: begin
					pend_v_q <= 1'b0;
					if (act_q == stq_pkg::ACT_ALLOC) begin
						if (free_found) begin
							status_q[free_idx] <= stq_pkg::ST_ALLOC;
						end
					end else if ((act_q == stq_pkg::ACT_FREE) && !cmd_bad) begin
						status_q[idx] <= stq_pkg::ST_FREE;
					end else if ((act_q == stq_pkg::ACT_ARM) && !cmd_bad) begin
						status_q[idx] <= stq_pkg::ST_RUN;
					end else if (act_q == stq_pkg::ACT_TICK) begin
						tick_q <= tick_q + 32'd1;
					end
				end
				stq_pkg::S_HEAD: begin
					head_q  <= idx;
					early_q <= d_q;
					run_q   <= run_q + CW'(1);
				end
				stq_pkg::S_LINK2: begin
					run_q <= run_q + CW'(1);
				end
				stq_pkg::S_TK_CHK: begin
					if (expire) begin
						status_q[cur_q] <= stq_pkg::ST_ALLOC;
						pend_v_q        <= 1'b1;
					end
				end
				stq_pkg::S_TK_END: begin
					if (out_free) begin
						run_q   <= remain;
						head_q  <= cur_q;
						early_q <= (remain != '0) ? rd.deadline : stq_pkg::NO_DUE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Command fields, walk registers, pending expiry and output payload.
	always_ff @(posedge clk) begin
		if ((state_q == stq_pkg::S_IDLE) && in_valid) begin
			act_q   <= action;
			tidx_q  <= timer_index;
			delay_q <= delay;
			tag_q   <= tag;
			qid_q   <= queue_id;
		end
		unique case (state_q)
			stq_pkg::S_DECODE: begin
				d_q    <= arm_sum;
				prev_q <= head_q;
				cur_q  <= head_q;
				n_q    <= (act_q == stq_pkg::ACT_TICK) ? CW'(0) : CW'(1);
				if (act_q == stq_pkg::ACT_ALLOC) begin
					res_kind_q <= free_found ? stq_pkg::KIND_GRANT : stq_pkg::KIND_REFUSE;
					res_slot_q <= free_found ? 5'(free_idx) : 5'd0;
				end else if ((act_q == stq_pkg::ACT_FREE) || (act_q == stq_pkg::ACT_SET) ||
						(act_q == stq_pkg::ACT_ARM)) begin
					res_kind_q <= cmd_bad ? stq_pkg::KIND_REFUSE : stq_pkg::KIND_ACK;
					res_slot_q <= tidx_q;
				end else begin
					res_kind_q <= stq_pkg::KIND_REFUSE;
					res_slot_q <= 5'd0;
				end
			end
			stq_pkg::S_WALK_D: begin
				cur_q <= rd.link;
			end
			stq_pkg::S_WALK_C: begin
				if (d_q > rd.deadline) begin
					prev_q <= cur_q;
					n_q    <= n_q + CW'(1);
				end
			end
			stq_pkg::S_TK_CHK: begin
				if (expire) begin
					pend_slot_q  <= cur_q;
					pend_tag_q   <= rd.tag;
					pend_queue_q <= rd.queue;
					cur_q        <= rd.link;
					n_q          <= n_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_kind_q  <= ol_kind;
			out_slot_q  <= ol_slot;
			out_tag_q   <= ol_tag;
			out_queue_q <= ol_queue;
			out_last_q  <= ol_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign slot         = out_slot_q;
	assign expired_tag  = out_tag_q;
	assign target_queue = out_queue_q;
	assign last         = out_last_q;

endmodule
